// ===== src/point_cluster_merge_core_assert.svh =====
`ifndef POINT_CLUSTER_MERGE_CORE_ASSERT_SVH
`define POINT_CLUSTER_MERGE_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define PCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("point_cluster_merge_core: assertion failed");

// Next-cycle implication, checked while out of reset.
`define PCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("point_cluster_merge_core: assertion failed");

`endif

// ===== src/pcm_pkg.sv =====
package pcm_pkg;

    localparam int TABLE_DEPTH_DEF = 16;

    localparam int COORD_W  = 12;
    localparam int WEIGHT_W = 8;
    localparam int CFG_W    = 12;
    localparam int DIV_STEPS = 12;   // quotient always fits in a coordinate

    localparam logic [COORD_W-1:0]  TOL_RESET  = 12'd10;
    localparam logic [WEIGHT_W-1:0] MINW_RESET = 8'd2;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 8'hFF;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 8'd1;

    typedef enum logic {
        REG_TOLERANCE  = 1'b0,
        REG_MIN_WEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic               last_point;
    } t_point_in;

    typedef struct packed {
        logic [COORD_W-1:0]  cluster_x;
        logic [COORD_W-1:0]  cluster_y;
        logic [WEIGHT_W-1:0] cluster_weight;
        logic                no_cluster;
        logic                overflow;
        logic                last_result;
    } t_cluster_out;

    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [WEIGHT_W-1:0] w;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOL,
        S_LIM,
        S_READ,
        S_DX,
        S_DY,
        S_CMP,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_WRITE,
        S_PLACE,
        S_FRD,
        S_FCHK,
        S_FEND
    } t_state;

endpackage

// ===== src/pcm_ram.sv =====
module pcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/point_cluster_merge_core.sv =====
// Leader clustering with running centroids. A point is taken when start is
// high and busy is low; busy then stays high until the point is fully merged
// and, for a point marked last, until the report scan is over. One shared
// 12x12 multiplier and a 1-bit-per-cycle divider do all the math over the
// cluster table, which sits in a single RAM. Each stored cluster is read and
// its squared distance to the point compared with the squared tolerance; a
// match needs two 12-step divides for the new centroid. A last point adds a
// report scan over the table after the point is placed. Results come out as
// one-cycle strobes on o_strobe and cannot be stalled: the receiver must take
// each one in the cycle it appears. Configuration must be written only while
// busy is low; the core itself does not enforce this.
`include "point_cluster_merge_core_assert.svh"

module point_cluster_merge_core
    import pcm_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_point_in          i_point,
    input  logic               i_cfg_we,
    input  t_reg_idx           i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output logic               o_strobe,
    output t_cluster_out       o_result
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = 2 * COORD_W;
    localparam int DW = COORD_W + WEIGHT_W;     // dividend width
    localparam int QW = $clog2(DIV_STEPS);

    t_state r_state, n_state;

    // configuration
    logic [COORD_W-1:0]  r_tol;
    logic [WEIGHT_W-1:0] r_minw;

    // control
    logic [CW-1:0] r_used;
    logic [CW-1:0] r_idx;
    logic          r_ovf;
    logic          r_hit;
    logic          r_ypass;
    logic [QW-1:0] r_cnt;
    logic          r_pend_v;
    logic          r_strobe;

    // datapath
    t_point_in           r_pt;
    logic [PW-1:0]       r_prod;
    logic [PW-1:0]       r_acc;
    logic [PW-1:0]       r_lim;
    logic [COORD_W-1:0]  r_cx, r_cy;
    logic [WEIGHT_W-1:0] r_w;
    logic [WEIGHT_W:0]   r_divisor;
    logic [WEIGHT_W:0]   r_rem;
    logic [COORD_W-1:0]  r_quo;
    logic [COORD_W-1:0]  r_nx;
    t_entry              r_pend;
    t_cluster_out        r_out;

    // RAM and shared units
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    t_entry             ram_wentry;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             ent;
    logic [COORD_W-1:0] mul_a, mul_b;
    logic [PW-1:0]      mul_p;
    logic [COORD_W-1:0] dx, dy;
    logic [PW:0]        dist_sq;
    logic               match;
    logic               idx_last;
    logic               div_done;
    logic [DW-1:0]      dividend;
    logic [WEIGHT_W+1:0] trial;
    logic               trial_ge;
    logic               qualifies;
    logic [WEIGHT_W-1:0] w_inc;

    pcm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wentry),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign ent      = t_entry'(ram_rdata);
    assign dx       = (ent.x >= r_pt.point_x) ? ent.x - r_pt.point_x : r_pt.point_x - ent.x;
    assign dy       = (r_cy >= r_pt.point_y) ? r_cy - r_pt.point_y : r_pt.point_y - r_cy;
    assign mul_p    = mul_a * mul_b;
    assign dist_sq  = {1'b0, r_acc} + {1'b0, r_prod};
    assign match    = dist_sq < {1'b0, r_lim};
    assign idx_last = (r_idx + CW'(1)) == r_used;
    assign div_done = r_cnt == QW'(DIV_STEPS - 1);
    assign dividend = r_prod[DW-1:0]
                    + {{(DW-COORD_W){1'b0}}, r_ypass ? r_pt.point_y : r_pt.point_x};
    assign trial    = {r_rem, r_quo[COORD_W-1]};
    assign trial_ge = trial >= {1'b0, r_divisor};
    assign qualifies = ent.w >= r_minw;
    assign w_inc    = (r_w == WEIGHT_MAX) ? r_w : r_w + WEIGHT_ONE;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_TOL;
            S_TOL:   n_state = S_LIM;
            S_LIM:   n_state = (r_used == '0) ? S_PLACE : S_READ;
            S_READ:  n_state = S_DX;
            S_DX:    n_state = S_DY;
            S_DY:    n_state = S_CMP;
            S_CMP: begin
                if (match) n_state = S_MUL;
                else if (idx_last) n_state = S_PLACE;
                else n_state = S_READ;
            end
            S_MUL:   n_state = S_LOAD;
            S_LOAD:  n_state = S_DIV;
            S_DIV: begin
                if (div_done) n_state = r_ypass ? S_WRITE : S_MUL;
            end
            S_WRITE: n_state = idx_last ? S_PLACE : S_READ;
            S_PLACE: n_state = r_pt.last_point ? S_FRD : S_IDLE;
            S_FRD:   n_state = S_FCHK;
            S_FCHK:  n_state = idx_last ? S_FEND : S_FRD;
            S_FEND:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs: RAM write port and multiplier operands
    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = r_idx[AW-1:0];
        ram_wentry = '{x: r_nx, y: r_quo, w: w_inc};
        mul_a      = r_tol;
        mul_b      = r_tol;
        unique case (r_state)
            S_DX: begin
                mul_a = dx;
                mul_b = dx;
            end
            S_DY: begin
                mul_a = dy;
                mul_b = dy;
            end
            S_MUL: begin
                mul_a = r_ypass ? r_cy : r_cx;
                mul_b = {{(COORD_W-WEIGHT_W){1'b0}}, r_w};
            end
            S_WRITE: ram_we = 1'b1;
            S_PLACE: begin
                ram_we     = ~r_hit && (r_used != CW'(TABLE_DEPTH));
                ram_waddr  = r_used[AW-1:0];
                ram_wentry = '{x: r_pt.point_x, y: r_pt.point_y, w: WEIGHT_ONE};
            end
            default: ;
        endcase
    end

    assign busy = r_state != S_IDLE;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tol    <= TOL_RESET;
            r_minw   <= MINW_RESET;
            r_used   <= '0;
            r_idx    <= '0;
            r_ovf    <= 1'b0;
            r_hit    <= 1'b0;
            r_ypass  <= 1'b0;
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            // a held entry goes out when the next one qualifies; the last one at the end
            r_strobe <= (r_state == S_FCHK && qualifies && r_pend_v) || (r_state == S_FEND);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_TOLERANCE:  r_tol  <= i_cfg_data;
                    REG_MIN_WEIGHT: r_minw <= i_cfg_data[WEIGHT_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    r_hit <= 1'b0;
                end
                S_CMP: begin
                    if (match) begin
                        r_hit   <= 1'b1;
                        r_ypass <= 1'b0;
                    end else if (!idx_last) begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_LOAD:  r_cnt <= '0;
                S_DIV: begin
                    r_cnt <= r_cnt + QW'(1);
                    if (div_done) r_ypass <= 1'b1;
                end
                S_WRITE: if (!idx_last) r_idx <= r_idx + CW'(1);
                S_PLACE: begin
                    r_idx    <= '0;
                    r_pend_v <= 1'b0;
                    if (!r_hit) begin
                        if (r_used != CW'(TABLE_DEPTH)) r_used <= r_used + CW'(1);
                        else r_ovf <= 1'b1;
                    end
                end
                S_FCHK: begin
                    if (qualifies) r_pend_v <= 1'b1;
                    if (!idx_last) r_idx <= r_idx + CW'(1);
                end
                S_FEND: begin
                    r_used   <= '0;
                    r_ovf    <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE:  if (start) r_pt <= i_point;
            S_TOL:   r_prod <= mul_p;
            S_LIM:   r_lim <= r_prod;
            S_DX: begin
                r_cx      <= ent.x;
                r_cy      <= ent.y;
                r_w       <= ent.w;
                r_divisor <= {1'b0, ent.w} + {{WEIGHT_W{1'b0}}, 1'b1};
                r_prod    <= mul_p;
            end
            S_DY: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            S_MUL:   r_prod <= mul_p;
            S_LOAD: begin
                if (r_ypass) r_nx <= r_quo;
                r_rem <= {1'b0, dividend[DW-1:COORD_W]};
                r_quo <= dividend[COORD_W-1:0];
            end
            S_DIV: begin
                r_rem <= trial_ge ? (WEIGHT_W+1)'(trial - {1'b0, r_divisor})
                                  : trial[WEIGHT_W:0];
                r_quo <= {r_quo[COORD_W-2:0], trial_ge};
            end
            S_FCHK: begin
                if (qualifies) begin
                    r_pend <= ent;
                    if (r_pend_v) begin
                        r_out <= '{cluster_x: r_pend.x, cluster_y: r_pend.y,
                                   cluster_weight: r_pend.w, no_cluster: 1'b0,
                                   overflow: r_ovf, last_result: 1'b0};
                    end
                end
            end
            S_FEND: begin
                if (r_pend_v) begin
                    r_out <= '{cluster_x: r_pend.x, cluster_y: r_pend.y,
                               cluster_weight: r_pend.w, no_cluster: 1'b0,
                               overflow: r_ovf, last_result: 1'b1};
                end else begin
                    r_out <= '{cluster_x: '0, cluster_y: '0, cluster_weight: '0,
                               no_cluster: 1'b1, overflow: r_ovf, last_result: 1'b1};
                end
            end
            default: ;
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    `PCM_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= CW'(TABLE_DEPTH))
    `PCM_ASSERT_IMP(a_rem_below_div, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_divisor)
    `PCM_ASSERT_IMP(a_empty_is_last, i_clk, i_rst_n, o_strobe && o_result.no_cluster, o_result.last_result)
    `PCM_ASSERT_IMP(a_cleared_after_report, i_clk, i_rst_n, o_strobe && o_result.last_result, r_used == '0 && !r_ovf)
    `PCM_ASSERT_NXT(a_strobe_source, i_clk, i_rst_n, r_state != S_FCHK && r_state != S_FEND, !o_strobe)

endmodule
